// ===== sv/sfu_pkg.sv =====
// sfu_pkg: shared types and constants of the spring force unit
// payload structs, configuration register indexes and mode codes; no dependencies
package sfu_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int CFG_IDX_W     = 3;
    localparam int CFG_DATA_W    = 32;

    // spring mode codes, the unused code behaves as a plain spring
    typedef enum logic [1:0] {
        MODE_SPRING = 2'd0,
        MODE_ANCHOR = 2'd1,
        MODE_BUNGEE = 2'd2
    } t_mode;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MODE     = 3'd0,
        REG_SPRING_K = 3'd1,
        REG_REST_LEN = 3'd2,
        REG_ANCHOR_X = 3'd3,
        REG_ANCHOR_Y = 3'd4,
        REG_ANCHOR_Z = 3'd5
    } t_cfg_reg;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [31:0] other_x;
        logic signed [31:0] other_y;
        logic signed [31:0] other_z;
    } t_sfu_in;

    typedef struct packed {
        logic signed [31:0] force_x;
        logic signed [31:0] force_y;
        logic signed [31:0] force_z;
        logic               applied;
        logic               saturated;
    } t_sfu_out;

endpackage

// ===== sv/spring_force_unit.sv =====
// spring_force_unit: pipelined hooke's law spring force in fixed point
// depends on sfu_pkg for payload structs, register indexes and mode codes

// The unit takes one item (particle position and a second point) per clock
// while start is high; busy stays low, so a transfer can happen every cycle.
// Each item yields exactly one result, shown on o_result for one cycle with
// o_done high, from the output register. The 73 register stages are: the
// difference, square and sum registers, 34 stages of a bit-pair square
// root, the stretch, partial product and divider setup registers forming
// |d| * k * abs(L - rest) with 32x34 partial products, 32 stages of a
// restoring divider (one quotient bit per stage) and one output register.
// Results leave in input order and the receiver cannot stall them.
// Configuration is written through i_cfg_we / i_cfg_idx / i_cfg_data and
// must only change while no item is in flight.
module spring_force_unit import sfu_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  t_sfu_in               i_item,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output logic                  o_done,
    output t_sfu_out              o_result
);

    localparam int SQ_N   = 34;   // root bits, one per stage
    localparam int RAD_W  = 2 * SQ_N;
    localparam int REM_W  = SQ_N + 2;
    localparam int CUR_W  = REM_W + 2;
    localparam int DV_N   = 32;   // quotient bits, one per stage
    localparam int N_W    = 98;   // product |d| * k * diff

    // ---------------------------------------------------------------
    // configuration registers
    // ---------------------------------------------------------------
    logic [1:0]         r_mode;
    logic [31:0]        r_k;
    logic [30:0]        r_rest;
    logic signed [31:0] r_anc_x, r_anc_y, r_anc_z;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= 2'd0;
            r_k     <= 32'd0;
            r_rest  <= 31'd0;
            r_anc_x <= 32'sd0;
            r_anc_y <= 32'sd0;
            r_anc_z <= 32'sd0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_reg'(i_cfg_idx))
                REG_MODE:     r_mode  <= i_cfg_data[1:0];
                REG_SPRING_K: r_k     <= i_cfg_data;
                REG_REST_LEN: r_rest  <= i_cfg_data[30:0];
                REG_ANCHOR_X: r_anc_x <= i_cfg_data;
                REG_ANCHOR_Y: r_anc_y <= i_cfg_data;
                REG_ANCHOR_Z: r_anc_z <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // the pipeline never holds back a transfer
    assign busy = 1'b0;

    // ---------------------------------------------------------------
    // stage 0: d = p - q, 33-bit exact
    // ---------------------------------------------------------------
    logic [31:0]       n0_p [3];
    logic [31:0]       n0_q [3];
    logic [2:0][32:0]  n0_d;
    logic              r0_v;
    logic [2:0][32:0]  r0_d;

    always_comb begin
        n0_p[0] = i_item.pos_x;
        n0_p[1] = i_item.pos_y;
        n0_p[2] = i_item.pos_z;
        if (r_mode == MODE_ANCHOR) begin
            n0_q[0] = r_anc_x;
            n0_q[1] = r_anc_y;
            n0_q[2] = r_anc_z;
        end else begin
            n0_q[0] = i_item.other_x;
            n0_q[1] = i_item.other_y;
            n0_q[2] = i_item.other_z;
        end
        for (int c = 0; c < 3; c++) begin
            n0_d[c] = {n0_p[c][31], n0_p[c]} - {n0_q[c][31], n0_q[c]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_v <= 1'b0;
        end else begin
            r0_v <= start & ~busy;
        end
        r0_d <= n0_d;
    end

    // ---------------------------------------------------------------
    // stage 1: magnitude (always below 2^32), square and |d| * k
    // ---------------------------------------------------------------
    logic [2:0][32:0]  n1_negd;
    logic [2:0][31:0]  n1_mag;
    logic [2:0]        n1_neg;
    logic              r1_v;
    logic [2:0][63:0]  r1_sq;
    logic [2:0][63:0]  r1_p;
    logic [2:0]        r1_neg;

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            n1_negd[c] = 33'd0 - r0_d[c];
            n1_mag[c]  = r0_d[c][32] ? n1_negd[c][31:0] : r0_d[c][31:0];
            // force points against d, so it is negative where d is positive
            n1_neg[c]  = ~r0_d[c][32] & (r0_d[c] != 33'd0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
        end else begin
            r1_v <= r0_v;
        end
        for (int c = 0; c < 3; c++) begin
            r1_sq[c] <= n1_mag[c] * n1_mag[c];
            r1_p[c]  <= n1_mag[c] * r_k;
        end
        r1_neg <= n1_neg;
    end

    // ---------------------------------------------------------------
    // square root pipeline, stage 0 holds the sum of squares
    // ---------------------------------------------------------------
    logic                    r_sq_v    [SQ_N+1];
    logic [RAD_W-1:0]        r_sq_rad  [SQ_N+1];
    logic [REM_W-1:0]        r_sq_rem  [SQ_N+1];
    logic [SQ_N-1:0]         r_sq_root [SQ_N+1];
    logic [2:0][63:0]        r_sq_p    [SQ_N+1];
    logic [2:0]              r_sq_neg  [SQ_N+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sq_v[0] <= 1'b0;
        end else begin
            r_sq_v[0] <= r1_v;
        end
        r_sq_rad[0]  <= RAD_W'(r1_sq[0]) + RAD_W'(r1_sq[1]) + RAD_W'(r1_sq[2]);
        r_sq_rem[0]  <= '0;
        r_sq_root[0] <= '0;
        r_sq_p[0]    <= r1_p;
        r_sq_neg[0]  <= r1_neg;
    end

    for (genvar i = 0; i < SQ_N; i++) begin : g_sqrt
        logic [CUR_W-1:0] n_cur;
        logic [CUR_W-1:0] n_trial;
        logic             n_ge;

        always_comb begin
            n_cur   = {r_sq_rem[i], r_sq_rad[i][RAD_W-1 -: 2]};
            n_trial = {2'b00, r_sq_root[i], 2'b01};
            n_ge    = (n_cur >= n_trial);
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sq_v[i+1] <= 1'b0;
            end else begin
                r_sq_v[i+1] <= r_sq_v[i];
            end
            r_sq_rem[i+1]  <= n_ge ? REM_W'(n_cur - n_trial) : REM_W'(n_cur);
            r_sq_root[i+1] <= {r_sq_root[i][SQ_N-2:0], n_ge};
            r_sq_rad[i+1]  <= {r_sq_rad[i][RAD_W-3:0], 2'b00};
            r_sq_p[i+1]    <= r_sq_p[i];
            r_sq_neg[i+1]  <= r_sq_neg[i];
        end
    end

    // ---------------------------------------------------------------
    // stage d: stretch abs(L - rest), slack bungee and zero length
    // ---------------------------------------------------------------
    logic [SQ_N-1:0] n_len;
    logic [SQ_N-1:0] n_rest;
    logic            rd_v;
    logic [SQ_N-1:0] rd_len;
    logic [SQ_N-1:0] rd_diff;
    logic [2:0][63:0] rd_p;
    logic [2:0]      rd_neg;
    logic            rd_slack;
    logic            rd_zero;

    assign n_len  = r_sq_root[SQ_N];
    assign n_rest = SQ_N'(r_rest);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            rd_v <= 1'b0;
        end else begin
            rd_v <= r_sq_v[SQ_N];
        end
        rd_len   <= n_len;
        rd_diff  <= (n_len >= n_rest) ? (n_len - n_rest) : (n_rest - n_len);
        rd_p     <= r_sq_p[SQ_N];
        rd_neg   <= r_sq_neg[SQ_N];
        rd_slack <= (r_mode == MODE_BUNGEE) && (n_len <= n_rest);
        rd_zero  <= (n_len == '0);
    end

    // ---------------------------------------------------------------
    // stage e: partial products of (|d| * k) * diff
    // ---------------------------------------------------------------
    logic             re_v;
    logic [2:0][65:0] re_pl;
    logic [2:0][65:0] re_ph;
    logic [SQ_N-1:0]  re_len;
    logic [2:0]       re_neg;
    logic             re_slack;
    logic             re_zero;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            re_v <= 1'b0;
        end else begin
            re_v <= rd_v;
        end
        for (int c = 0; c < 3; c++) begin
            re_pl[c] <= rd_p[c][31:0] * rd_diff;
            re_ph[c] <= rd_p[c][63:32] * rd_diff;
        end
        re_len   <= rd_len;
        re_neg   <= rd_neg;
        re_slack <= rd_slack;
        re_zero  <= rd_zero;
    end

    // ---------------------------------------------------------------
    // stage f: drop fraction bits, overflow check, divider setup
    // floor(n / (L << F)) equals floor(floor(n >> F) / L)
    // ---------------------------------------------------------------
    logic [N_W-1:0]  nf_n   [3];
    logic [N_W-1:0]  nf_sh  [3];
    logic [N_W-33:0] nf_hi  [3];
    logic [2:0]      nf_ovf;

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            nf_n[c]   = N_W'(re_pl[c]) + {re_ph[c], 32'd0};
            nf_sh[c]  = nf_n[c] >> FRAC_BITS;
            nf_hi[c]  = nf_sh[c][N_W-1:32];
            // quotient of 2^32 or more
            nf_ovf[c] = (nf_hi[c] >= (N_W-32)'(re_len));
        end
    end

    logic                 r_dv_v     [DV_N+1];
    logic [2:0][SQ_N-1:0] r_dv_rem   [DV_N+1];
    logic [2:0][31:0]     r_dv_low   [DV_N+1];
    logic [2:0][31:0]     r_dv_q     [DV_N+1];
    logic [SQ_N-1:0]      r_dv_len   [DV_N+1];
    logic [2:0]           r_dv_neg   [DV_N+1];
    logic [2:0]           r_dv_ovf   [DV_N+1];
    logic                 r_dv_slack [DV_N+1];
    logic                 r_dv_zero  [DV_N+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv_v[0] <= 1'b0;
        end else begin
            r_dv_v[0] <= re_v;
        end
        for (int c = 0; c < 3; c++) begin
            r_dv_rem[0][c] <= nf_hi[c][SQ_N-1:0];
            r_dv_low[0][c] <= nf_sh[c][31:0];
        end
        r_dv_q[0]     <= '0;
        r_dv_len[0]   <= re_len;
        r_dv_neg[0]   <= re_neg;
        r_dv_ovf[0]   <= nf_ovf;
        r_dv_slack[0] <= re_slack;
        r_dv_zero[0]  <= re_zero;
    end

    for (genvar j = 0; j < DV_N; j++) begin : g_div
        logic [SQ_N:0]   n_cur [3];
        logic [SQ_N:0]   n_dif [3];
        logic [2:0]      n_ge;

        always_comb begin
            for (int c = 0; c < 3; c++) begin
                n_cur[c] = {r_dv_rem[j][c], r_dv_low[j][c][31]};
                n_dif[c] = n_cur[c] - {1'b0, r_dv_len[j]};
                n_ge[c]  = (n_cur[c] >= {1'b0, r_dv_len[j]});
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv_v[j+1] <= 1'b0;
            end else begin
                r_dv_v[j+1] <= r_dv_v[j];
            end
            for (int c = 0; c < 3; c++) begin
                r_dv_rem[j+1][c] <= n_ge[c] ? n_dif[c][SQ_N-1:0] : n_cur[c][SQ_N-1:0];
                r_dv_q[j+1][c]   <= {r_dv_q[j][c][30:0], n_ge[c]};
                r_dv_low[j+1][c] <= {r_dv_low[j][c][30:0], 1'b0};
            end
            r_dv_len[j+1]   <= r_dv_len[j];
            r_dv_neg[j+1]   <= r_dv_neg[j];
            r_dv_ovf[j+1]   <= r_dv_ovf[j];
            r_dv_slack[j+1] <= r_dv_slack[j];
            r_dv_zero[j+1]  <= r_dv_zero[j];
        end
    end

    // ---------------------------------------------------------------
    // output stage: saturate, apply sign, special cases
    // ---------------------------------------------------------------
    logic [31:0] no_lim [3];
    logic [31:0] no_mag [3];
    logic [31:0] no_f   [3];
    logic [2:0]  no_sat;
    t_sfu_out    n_out;
    logic        r_done;
    t_sfu_out    r_out;

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            no_lim[c] = r_dv_neg[DV_N][c] ? 32'h8000_0000 : 32'h7FFF_FFFF;
            no_sat[c] = r_dv_ovf[DV_N][c] | (r_dv_q[DV_N][c] > no_lim[c]);
            no_mag[c] = no_sat[c] ? no_lim[c] : r_dv_q[DV_N][c];
            no_f[c]   = r_dv_neg[DV_N][c] ? (32'd0 - no_mag[c]) : no_mag[c];
        end
        n_out.force_x   = no_f[0];
        n_out.force_y   = no_f[1];
        n_out.force_z   = no_f[2];
        n_out.applied   = 1'b1;
        n_out.saturated = |no_sat;
        priority if (r_dv_slack[DV_N]) begin
            // slack bungee, zero length in bungee mode lands here too
            n_out = '0;
        end else if (r_dv_zero[DV_N]) begin
            n_out         = '0;
            n_out.applied = 1'b1;
        end else begin
            // ordinary force, already formed above
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= r_dv_v[DV_N];
        end
        r_out <= n_out;
    end

    assign o_done   = r_done;
    assign o_result = r_out;

endmodule

// ===== bench/tb_spring_force_unit.sv =====
// tb_spring_force_unit: self-checking bench for the pipelined spring force unit
// depends on sfu_pkg and spring_force_unit; predicts every result in a scoreboard class

module tb_spring_force_unit;
    import sfu_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // mode code outside the enum, must act as a plain spring
    localparam logic [1:0] MODE_UNUSED = 2'd3;
    localparam int LATENCY     = 73;
    localparam int CYCLE_LIMIT = 200000;

    // expected forces of transfers still in the pipeline, plus a copy of the registers
    class force_scoreboard;
        logic [1:0]         mode;
        logic [31:0]        spring_k;
        logic [30:0]        rest_len;
        logic signed [31:0] anchor [3];
        t_sfu_out           pending_forces [$];
        int                 fail_count;

        function new();
            mode       = MODE_SPRING;
            spring_k   = '0;
            rest_len   = '0;
            anchor     = '{default: '0};
            fail_count = 0;
        endfunction

        function void set_reg(t_cfg_reg idx, logic [31:0] value);
            case (idx)
                REG_MODE:     mode      = value[1:0];
                REG_SPRING_K: spring_k  = value;
                REG_REST_LEN: rest_len  = value[30:0];
                REG_ANCHOR_X: anchor[0] = value;
                REG_ANCHOR_Y: anchor[1] = value;
                REG_ANCHOR_Z: anchor[2] = value;
                default: ;
            endcase
        endfunction

        function t_sfu_out spring_force(t_sfu_in it);
            logic signed [31:0] p [3];
            logic signed [31:0] q [3];
            logic signed [32:0] d [3];
            logic [32:0]        mag [3];
            logic [127:0]       sum_sq, cand, num, quo, lim;
            logic [63:0]        len, diff, divisor;
            logic [31:0]        v;
            logic               neg, sat;
            t_sfu_out           r;
            p = '{it.pos_x, it.pos_y, it.pos_z};
            if (mode == MODE_ANCHOR) q = anchor;
            else q = '{it.other_x, it.other_y, it.other_z};
            sum_sq = '0;
            for (int i = 0; i < 3; i++) begin
                d[i]   = $signed({p[i][31], p[i]}) - $signed({q[i][31], q[i]});
                mag[i] = d[i][32] ? 33'(-d[i]) : 33'(d[i]);
                sum_sq = sum_sq + 128'(mag[i]) * 128'(mag[i]);
            end
            // bitwise integer square root of the raw sum
            len = '0;
            for (int b = 33; b >= 0; b--) begin
                cand = 128'(len | (64'd1 << b));
                if (cand * cand <= sum_sq) len = cand[63:0];
            end
            r = '0;
            r.applied = 1'b1;
            // slack bungee
            if (mode == MODE_BUNGEE && len <= 64'(rest_len)) begin
                r.applied = 1'b0;
                return r;
            end
            // zero length: no direction, no force
            if (len == 0) return r;
            diff    = (len >= 64'(rest_len)) ? len - 64'(rest_len) : 64'(rest_len) - len;
            divisor = len << FRAC_BITS_DEF;
            sat = 1'b0;
            for (int i = 0; i < 3; i++) begin
                neg = !d[i][32] && d[i] != 0;
                lim = neg ? 128'h8000_0000 : 128'h7FFF_FFFF;
                num = 128'(mag[i]) * 128'(spring_k) * 128'(diff);
                quo = num / 128'(divisor);
                if (quo > lim) begin
                    quo = lim;
                    sat = 1'b1;
                end
                v = neg ? -quo[31:0] : quo[31:0];
                case (i)
                    0: r.force_x = v;
                    1: r.force_y = v;
                    default: r.force_z = v;
                endcase
            end
            r.saturated = sat;
            return r;
        endfunction

        function void note_transfer(t_sfu_in it);
            pending_forces.insert(pending_forces.size(), spring_force(it));
        endfunction

        function void check_result(t_sfu_out got);
            t_sfu_out want;
            if (pending_forces.size() == 0) begin
                $error("result with no transfer outstanding: %h", got);
                fail_count++;
                return;
            end
            want = pending_forces.pop_front();
            if (got.force_x !== want.force_x) begin
                $error("force_x expected %h actual %h", want.force_x, got.force_x);
                fail_count++;
            end
            if (got.force_y !== want.force_y) begin
                $error("force_y expected %h actual %h", want.force_y, got.force_y);
                fail_count++;
            end
            if (got.force_z !== want.force_z) begin
                $error("force_z expected %h actual %h", want.force_z, got.force_z);
                fail_count++;
            end
            if (got.applied !== want.applied) begin
                $error("applied expected %b actual %b", want.applied, got.applied);
                fail_count++;
            end
            if (got.saturated !== want.saturated) begin
                $error("saturated expected %b actual %b", want.saturated, got.saturated);
                fail_count++;
            end
        endfunction
    endclass

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  start = 1'b0;
    logic                  busy;
    t_sfu_in               i_item = '0;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  o_done;
    t_sfu_out              o_result;

    force_scoreboard sb = new();
    bit              idle_enable = 1'b1;
    int              cycle_count = 0;

    spring_force_unit i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_item     (i_item),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_done     (o_done),
        .o_result   (o_result)
    );

    always #5 i_clk = ~i_clk;

    // watchdog: a hung handshake or lost result ends the run here
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // results cannot be stalled, so every strobe is a transfer
    always @(posedge i_clk) begin
        if (i_rst_n && o_done) sb.check_result(o_result);
    end

    // register write at the falling edge, lands on the next rising edge
    task automatic write_reg(t_cfg_reg idx, logic [31:0] value);
        @(negedge i_clk);
        i_cfg_we   = 1'b1;
        i_cfg_idx  = idx;
        i_cfg_data = value;
        @(negedge i_clk);
        i_cfg_we   = 1'b0;
        sb.set_reg(idx, value);
    endtask

    // wait until the pipeline holds nothing, then a few spare cycles
    task automatic drain();
        while (sb.pending_forces.size() != 0) @(posedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic program_unit(logic [1:0] mode, logic [31:0] k, logic [31:0] rest,
                                logic [31:0] ax, logic [31:0] ay, logic [31:0] az);
        drain();
        write_reg(REG_MODE, 32'(mode));
        write_reg(REG_SPRING_K, k);
        write_reg(REG_REST_LEN, rest);
        write_reg(REG_ANCHOR_X, ax);
        write_reg(REG_ANCHOR_Y, ay);
        write_reg(REG_ANCHOR_Z, az);
    endtask

    // drive one item from a falling edge, hold it until a rising edge accepts it
    // each cycle idles with a chance of 36 in a hundred
    task automatic send_item(t_sfu_in it);
        bit taken;
        while (idle_enable && $urandom_range(99) < 36) begin
            start = 1'b0;
            @(negedge i_clk);
        end
        start  = 1'b1;
        i_item = it;
        taken  = 1'b0;
        while (!taken) begin
            @(posedge i_clk);
            taken = !busy;
        end
        sb.note_transfer(it);
        @(negedge i_clk);
        start = 1'b0;
    endtask

    task automatic send_pair(logic [31:0] px, logic [31:0] py, logic [31:0] pz,
                             logic [31:0] ox, logic [31:0] oy, logic [31:0] oz);
        t_sfu_in it;
        it = '{px, py, pz, ox, oy, oz};
        send_item(it);
    endtask

    // mostly modest coordinates so forces stay in range, some full-width ones
    function automatic logic [31:0] rand_coord();
        case ($urandom_range(3))
            0:       return $urandom;
            1:       return 32'($signed($urandom_range(0, 32'h0040_0000)) - 32'sh0020_0000);
            default: return 32'($signed($urandom_range(0, 32'h0400_0000)) - 32'sh0200_0000);
        endcase
    endfunction

    function automatic logic [31:0] rand_k();
        case ($urandom_range(3))
            0:       return $urandom;
            1:       return $urandom_range(0, 32'h0000_FFFF);
            default: return $urandom_range(0, 32'h0010_0000);
        endcase
    endfunction

    initial begin
        logic [31:0] px, py, pz;
        repeat (2) @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: plain spring, unit stiffness, zero rest
        program_unit(MODE_SPRING, 32'h0001_0000, 32'h0, 32'h0, 32'h0, 32'h0);
        send_pair(32'h0001_0000, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0);
        send_pair(32'h1234_5678, 32'h8000_0000, 32'h7FFF_FFFF,
                  32'h1234_5678, 32'h8000_0000, 32'h7FFF_FFFF);   // zero length
        send_pair(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                  32'h8000_0000, 32'h8000_0000, 32'h8000_0000);   // widest separation
        send_pair(32'h8000_0000, 32'h0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0, 32'h8000_0000);
        send_pair(32'h0000_0001, 32'hFFFF_FFFF, 32'h0, 32'h0, 32'h0, 32'h0);

        // stiff spring, longest rest length: overflow both ways
        program_unit(MODE_SPRING, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h0, 32'h0, 32'h0);
        send_pair(32'h0003_0000, 32'hFFFC_0000, 32'h0, 32'h0, 32'h0, 32'h0);
        send_pair(32'h7FFF_FFFF, 32'h8000_0000, 32'h5555_5555, 32'h8000_0000, 32'h7FFF_FFFF,
                  32'hAAAA_AAAA);
        send_pair(32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0);

        // anchored, anchors at the extremes; other point ignored
        program_unit(MODE_ANCHOR, 32'h0002_0000, 32'h0001_0000,
                     32'h7FFF_FFFF, 32'h8000_0000, 32'h0);
        send_pair(32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'hDEAD_BEEF, 32'h1, 32'h2);
        send_pair(32'h8000_0000, 32'h7FFF_FFFF, 32'h0001_0000, 32'h0, 32'h0, 32'h0);
        send_pair(32'h7FFE_0000, 32'h8000_0000, 32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                  32'hFFFF_FFFF);

        // bungee: slack, exactly at rest, taut
        program_unit(MODE_BUNGEE, 32'h0001_8000, 32'h0005_0000, 32'h0, 32'h0, 32'h0);
        send_pair(32'h0003_0000, 32'h0004_0000, 32'h0, 32'h0, 32'h0, 32'h0);
        send_pair(32'h0001_0000, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0);
        send_pair(32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0);
        send_pair(32'h0009_0000, 32'h0, 32'hFFF0_0000, 32'h0, 32'h0, 32'h0);
        send_pair(32'h8000_0000, 32'h0, 32'h0, 32'h7FFF_FFFF, 32'h0, 32'h0);

        // unused mode code behaves as a spring to the other particle
        program_unit(MODE_UNUSED, 32'h0001_0000, 32'h0002_0000, 32'h0100_0000, 32'h0, 32'h0);
        send_pair(32'h0004_0000, 32'h0, 32'h0, 32'h0, 32'h0003_0000, 32'h0);
        send_pair(32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0);

        // random phases; sender pauses for a full drain at every reprogram
        for (int phase = 0; phase < 8; phase++) begin
            logic [1:0]  m;
            logic [31:0] rest;
            m    = 2'($urandom_range(0, 3));
            rest = (phase == 7) ? 32'h7FFF_FFFF
                 : ($urandom_range(3) == 0 ? $urandom : $urandom_range(0, 32'h0100_0000));
            program_unit(m, (phase == 6) ? 32'hFFFF_FFFF : rand_k(), rest,
                         rand_coord(), rand_coord(), rand_coord());
            idle_enable = (phase != 3);
            for (int n = 0; n < 50; n++) begin
                px = rand_coord();
                py = rand_coord();
                pz = rand_coord();
                // now and then the second point coincides or sits close by
                if ($urandom_range(19) == 0)
                    send_pair(px, py, pz, px, py, pz);
                else if ($urandom_range(4) == 0)
                    send_pair(px, py, pz, px + $urandom_range(0, 32'h0008_0000), py,
                              pz - $urandom_range(0, 32'h0008_0000));
                else
                    send_pair(px, py, pz, rand_coord(), rand_coord(), rand_coord());
            end
            idle_enable = 1'b1;
        end

        while (sb.pending_forces.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 8) @(posedge i_clk);
        if (sb.fail_count == 0 && sb.pending_forces.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
